[design/assert_macros.svh]
// Assertion macros used by the top level of the decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define IDRPD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define IDRPD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/idrpd_pkg.sv]
// Types and constants of the indexed, difference and run pixel decoder.
package idrpd_pkg;

    localparam int CACHE_ENTRIES = 64;
    localparam int CACHE_AW      = $clog2(CACHE_ENTRIES);
    localparam int RUN_W         = 6;
    localparam int SUM_W         = 15;
    localparam int PROD_W        = 2 * SUM_W;
    localparam int GRAY_SHIFT    = 21;

    localparam logic [7:0] TAG_RAW_CODE    = 8'hFE;
    localparam logic [7:0] TAG_REPEAT_CODE = 8'hFF;
    localparam logic [7:0] RUN_BIAS        = 8'd191;
    localparam logic [7:0] DIFF_BIAS       = 8'd254;
    localparam logic [7:0] LUMA_RB_BIAS    = 8'd40;
    localparam logic [7:0] LUMA_G_BIAS     = 8'd32;

    localparam logic [SUM_W-1:0] GRAY_WR    = 15'd30;
    localparam logic [SUM_W-1:0] GRAY_WG    = 15'd59;
    localparam logic [SUM_W-1:0] GRAY_WB    = 15'd11;
    // Reciprocal of 100 scaled by two to the GRAY_SHIFT, exact for sums up to 25500.
    localparam logic [SUM_W-1:0] GRAY_RECIP = 15'd20972;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_GRAY   = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        TAG_INDEX,
        TAG_DIFF,
        TAG_LUMA,
        TAG_RUN,
        TAG_RAW,
        TAG_REPEAT
    } t_tag;

    typedef enum logic [2:0] {
        SRC_PREV,
        SRC_RUN,
        SRC_DIFF,
        SRC_LUMA,
        SRC_RAW,
        SRC_CACHE
    } t_px_src;

    typedef enum logic [2:0] {
        ST_TAG,
        ST_LUMA,
        ST_RAW_R,
        ST_RAW_G,
        ST_RAW_B,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic    load;
        t_px_src src;
        logic    save_luma;
        logic    save_red;
        logic    save_green;
        logic    emit;
    } t_dp_cmd;

    typedef struct packed {
        t_tag tag;
        logic a_free;
        logic emit_last;
    } t_dp_stat;

endpackage

[design/idrpd_ctrl.sv]
// Chunk sequencing state machine of the pixel decoder.
module idrpd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  idrpd_pkg::t_dp_stat  i_stat,
    output idrpd_pkg::t_dp_cmd   o_cmd
);

    idrpd_pkg::t_state r_state;
    idrpd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= idrpd_pkg::ST_TAG;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            idrpd_pkg::ST_TAG: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_stat.tag)
                        idrpd_pkg::TAG_RAW: begin
                            n_state = idrpd_pkg::ST_RAW_R;
                        end
                        idrpd_pkg::TAG_LUMA: begin
                            o_cmd.save_luma = 1'b1;
                            n_state         = idrpd_pkg::ST_LUMA;
                        end
                        idrpd_pkg::TAG_INDEX: begin
                            o_cmd.load = 1'b1;
                            o_cmd.src  = idrpd_pkg::SRC_CACHE;
                            n_state    = idrpd_pkg::ST_EMIT;
                        end
                        idrpd_pkg::TAG_DIFF: begin
                            o_cmd.load = 1'b1;
                            o_cmd.src  = idrpd_pkg::SRC_DIFF;
                            n_state    = idrpd_pkg::ST_EMIT;
                        end
                        idrpd_pkg::TAG_RUN: begin
                            o_cmd.load = 1'b1;
                            o_cmd.src  = idrpd_pkg::SRC_RUN;
                            n_state    = idrpd_pkg::ST_EMIT;
                        end
                        default: begin
                            o_cmd.load = 1'b1;
                            o_cmd.src  = idrpd_pkg::SRC_PREV;
                            n_state    = idrpd_pkg::ST_EMIT;
                        end
                    endcase
                end
            end
            idrpd_pkg::ST_LUMA: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.src  = idrpd_pkg::SRC_LUMA;
                    n_state    = idrpd_pkg::ST_EMIT;
                end
            end
            idrpd_pkg::ST_RAW_R: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.save_red = 1'b1;
                    n_state        = idrpd_pkg::ST_RAW_G;
                end
            end
            idrpd_pkg::ST_RAW_G: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.save_green = 1'b1;
                    n_state          = idrpd_pkg::ST_RAW_B;
                end
            end
            idrpd_pkg::ST_RAW_B: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.src  = idrpd_pkg::SRC_RAW;
                    n_state    = idrpd_pkg::ST_EMIT;
                end
            end
            idrpd_pkg::ST_EMIT: begin
                if (i_stat.a_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = idrpd_pkg::ST_TAG;
                    end
                end
            end
            default: begin
                n_state = idrpd_pkg::ST_TAG;
            end
        endcase
    end

endmodule

[design/idrpd_dp.sv]
// Datapath of the pixel decoder: pixel state, color cache, frame counters and output stages.
module idrpd_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  idrpd_pkg::t_dp_cmd   i_cmd,
    output idrpd_pkg::t_dp_stat  o_stat,
    input  logic [7:0]           i_code_byte,
    input  logic                 i_cfg_valid,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green,
    output logic [7:0]           o_blue,
    output logic                 o_run_last,
    output logic                 o_frame_last
);

    logic [15:0] r_width;
    logic [15:0] r_height;
    logic        r_gray;

    logic [23:0] r_prev;
    logic [23:0] r_pend;
    logic        r_use_cache;
    logic        r_hit;
    logic [23:0] r_rdata;
    logic [idrpd_pkg::RUN_W-1:0] r_run_left;
    logic [7:0]  r_part_r;
    logic [7:0]  r_part_g;
    logic [15:0] r_col;
    logic [15:0] r_row;
    logic [idrpd_pkg::CACHE_ENTRIES-1:0] r_cache_vld;
    logic [23:0] r_cache_mem [idrpd_pkg::CACHE_ENTRIES];

    logic                        r_a_valid;
    logic [23:0]                 r_a_px;
    logic [idrpd_pkg::SUM_W-1:0] r_a_sum;
    logic                        r_a_run_last;
    logic                        r_a_frame_last;

    logic        r_o_valid;
    logic [7:0]  r_o_red;
    logic [7:0]  r_o_green;
    logic [7:0]  r_o_blue;
    logic        r_o_run_last;
    logic        r_o_frame_last;

    idrpd_pkg::t_tag dec_tag;
    logic        emit_last;
    logic        a_free;
    logic [7:0]  pr;
    logic [7:0]  pg;
    logic [7:0]  pb;
    logic [7:0]  dg;
    logic [23:0] load_px;
    logic [idrpd_pkg::RUN_W-1:0]    run_cnt;
    logic [7:0]                     run_diff;
    logic [idrpd_pkg::CACHE_AW-1:0] rd_addr;
    logic [23:0] cur_px;
    logic [7:0]  cr;
    logic [7:0]  cg;
    logic [7:0]  cb;
    logic [idrpd_pkg::CACHE_AW-1:0] hash;
    logic [idrpd_pkg::SUM_W-1:0]    gsum;
    logic [15:0] col_inc;
    logic [15:0] row_inc;
    logic        wrap;
    logic        frame_end;
    logic        o_adv;
    logic        a_adv;
    logic [idrpd_pkg::PROD_W-1:0] gprod;
    logic [7:0]  gray_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 16'd1;
            r_height <= 16'd1;
            r_gray   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                idrpd_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                idrpd_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                idrpd_pkg::CFG_GRAY:   r_gray   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (i_code_byte == idrpd_pkg::TAG_RAW_CODE) begin
            dec_tag = idrpd_pkg::TAG_RAW;
        end else if (i_code_byte == idrpd_pkg::TAG_REPEAT_CODE) begin
            dec_tag = idrpd_pkg::TAG_REPEAT;
        end else begin
            unique case (i_code_byte[7:6])
                2'b00:   dec_tag = idrpd_pkg::TAG_INDEX;
                2'b01:   dec_tag = idrpd_pkg::TAG_DIFF;
                2'b10:   dec_tag = idrpd_pkg::TAG_LUMA;
                default: dec_tag = idrpd_pkg::TAG_RUN;
            endcase
        end
    end

    assign o_stat = '{tag: dec_tag, a_free: a_free, emit_last: emit_last};

    assign pr = r_prev[23:16];
    assign pg = r_prev[15:8];
    assign pb = r_prev[7:0];
    assign dg = {2'b00, r_part_r[5:0]};

    always_comb begin
        unique case (i_cmd.src)
            idrpd_pkg::SRC_DIFF: begin
                load_px = {pr + {6'd0, i_code_byte[5:4]} + idrpd_pkg::DIFF_BIAS,
                           pg + {6'd0, i_code_byte[3:2]} + idrpd_pkg::DIFF_BIAS,
                           pb + {6'd0, i_code_byte[1:0]} + idrpd_pkg::DIFF_BIAS};
            end
            idrpd_pkg::SRC_LUMA: begin
                load_px = {pr + dg + {4'd0, i_code_byte[7:4]} - idrpd_pkg::LUMA_RB_BIAS,
                           pg + dg - idrpd_pkg::LUMA_G_BIAS,
                           pb + dg + {4'd0, i_code_byte[3:0]} - idrpd_pkg::LUMA_RB_BIAS};
            end
            idrpd_pkg::SRC_RAW: begin
                load_px = {r_part_r, r_part_g, i_code_byte};
            end
            default: begin
                load_px = r_prev;
            end
        endcase
    end

    assign run_diff = i_code_byte - idrpd_pkg::RUN_BIAS;
    assign run_cnt  = run_diff[idrpd_pkg::RUN_W-1:0];
    assign rd_addr  = i_code_byte[idrpd_pkg::CACHE_AW-1:0];

    assign cur_px = r_use_cache ? (r_hit ? r_rdata : 24'd0) : r_pend;
    assign cr     = cur_px[23:16];
    assign cg     = cur_px[15:8];
    assign cb     = cur_px[7:0];
    assign hash   = idrpd_pkg::CACHE_AW'(cr * 8'd3 + cg * 8'd5 + cb * 8'd7);
    assign gsum   = {7'd0, cr} * idrpd_pkg::GRAY_WR
                  + {7'd0, cg} * idrpd_pkg::GRAY_WG
                  + {7'd0, cb} * idrpd_pkg::GRAY_WB;

    assign col_inc   = r_col + 16'd1;
    assign row_inc   = r_row + 16'd1;
    assign wrap      = col_inc >= r_width;
    assign frame_end = wrap && (row_inc >= r_height);

    assign emit_last = (r_run_left == idrpd_pkg::RUN_W'(1)) || frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= 24'd0;
            r_col       <= 16'd0;
            r_row       <= 16'd0;
            r_cache_vld <= '0;
            r_run_left  <= '0;
            r_use_cache <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_use_cache <= (i_cmd.src == idrpd_pkg::SRC_CACHE);
                r_hit       <= r_cache_vld[rd_addr];
                r_run_left  <= (i_cmd.src == idrpd_pkg::SRC_RUN) ? run_cnt
                                                                   : idrpd_pkg::RUN_W'(1);
            end
            if (i_cmd.emit) begin
                r_run_left <= r_run_left - idrpd_pkg::RUN_W'(1);
                if (frame_end) begin
                    r_prev      <= 24'd0;
                    r_col       <= 16'd0;
                    r_row       <= 16'd0;
                    r_cache_vld <= '0;
                end else begin
                    r_prev            <= cur_px;
                    r_col             <= wrap ? 16'd0 : col_inc;
                    r_row             <= wrap ? row_inc : r_row;
                    r_cache_vld[hash] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_cache_mem[hash] <= cur_px;
        end
        if (i_cmd.load) begin
            r_rdata <= r_cache_mem[rd_addr];
            r_pend  <= load_px;
        end
        if (i_cmd.save_luma || i_cmd.save_red) begin
            r_part_r <= i_code_byte;
        end
        if (i_cmd.save_green) begin
            r_part_g <= i_code_byte;
        end
    end

    assign o_adv  = !r_o_valid || i_out_ready;
    assign a_adv  = r_a_valid && o_adv;
    assign a_free = !r_a_valid || o_adv;

    assign gprod  = idrpd_pkg::PROD_W'(r_a_sum) * idrpd_pkg::PROD_W'(idrpd_pkg::GRAY_RECIP);
    assign gray_y = gprod[idrpd_pkg::GRAY_SHIFT+7:idrpd_pkg::GRAY_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (a_adv) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_a_px         <= cur_px;
            r_a_sum        <= gsum;
            r_a_run_last   <= emit_last;
            r_a_frame_last <= frame_end;
        end
        if (a_adv) begin
            r_o_red        <= r_gray ? gray_y : r_a_px[23:16];
            r_o_green      <= r_gray ? gray_y : r_a_px[15:8];
            r_o_blue       <= r_gray ? gray_y : r_a_px[7:0];
            r_o_run_last   <= r_a_run_last;
            r_o_frame_last <= r_a_frame_last;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_red        = r_o_red;
    assign o_green      = r_o_green;
    assign o_blue       = r_o_blue;
    assign o_run_last   = r_o_run_last;
    assign o_frame_last = r_o_frame_last;

endmodule

[design/indexed_diff_run_pixel_decoder.sv]
// Top level of the indexed, difference and run pixel decoder.
//
//   Channel   Direction  Handshake                  Payload
//   cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//   in        in         i_in_valid / o_in_ready    i_code_byte
//   out       out        o_out_valid / i_out_ready  o_red, o_green, o_blue,
//                                                   o_run_last, o_frame_last
//
// A byte that yields no pixel only updates the decoder state; a byte that yields
// pixels is loaded, then emitted one by one through the emit step of the datapath.
// Reset is synchronous and active low; the cache valid bits clear in the same cycle.
// A stalled output holds the emit step once both output registers are full.
`include "assert_macros.svh"

module indexed_diff_run_pixel_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_code_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_run_last,
    output logic        o_frame_last
);

    idrpd_pkg::t_dp_cmd  s_cmd;
    idrpd_pkg::t_dp_stat s_stat;

    assign o_cfg_ready = 1'b1;

    idrpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd)
    );

    idrpd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (s_cmd),
        .o_stat       (s_stat),
        .i_code_byte  (i_code_byte),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_run_last   (o_run_last),
        .o_frame_last (o_frame_last)
    );

    `IDRPD_ASSERT(a_frame_implies_run_last, i_clk, i_rst_n, (o_out_valid && o_frame_last) |-> o_run_last, "frame end without run end")
    `IDRPD_ASSERT(a_no_input_after_load, i_clk, i_rst_n, (i_in_valid && o_in_ready && s_cmd.load) |=> !o_in_ready, "input taken while pixels pending")
    `IDRPD_ASSERT(a_emit_needs_space, i_clk, i_rst_n, s_cmd.emit |-> s_stat.a_free, "pixel emitted into a full stage")
    `IDRPD_ASSERT_ALWAYS(a_reset_clears_output, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

[tb/indexed_diff_run_pixel_decoder_test.sv]
// Self-checking testbench for the indexed, difference and run pixel decoder.
module indexed_diff_run_pixel_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] OP_MASK  = 8'hC0;
    localparam logic [7:0] OP_INDEX = 8'h00;
    localparam logic [7:0] OP_DIFF  = 8'h40;
    localparam logic [7:0] OP_LUMA  = 8'h80;
    localparam logic [7:0] OP_RUN   = 8'hC0;

    localparam int DIRECTED_ROWS = 31;
    localparam int PHASES        = 6;
    localparam int PHASE_CODES   = 37;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int LIMIT_CYCLES  = 2000000;
    localparam int REPORT_LIMIT  = 10;

    typedef enum logic [2:0] {
        PEND_NONE,
        PEND_LUMA,
        PEND_RED,
        PEND_GREEN,
        PEND_BLUE
    } t_pend;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       run_last;
        logic       frame_last;
    } t_pixel;

    typedef struct packed {
        logic                  is_cfg;
        idrpd_pkg::t_cfg_reg   reg_sel;
        logic [15:0]           value;
        logic [7:0]            code;
        logic                  typed;
        t_pixel                want;
    } t_step;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_code_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic        o_run_last;
    logic        o_frame_last;

    // Decoder state as predicted from the accepted code bytes and register writes.
    logic [23:0] last_px;
    logic [23:0] hue_cache [0:63];
    t_pend       pend_st;
    logic [7:0]  luma_first;
    logic [7:0]  raw_red;
    logic [7:0]  raw_green;
    logic [15:0] col_cnt;
    logic [15:0] row_cnt;
    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic        gray_on;

    t_pixel fresh_px [$];
    t_pixel expected_pixels [$];
    t_pixel got_px;
    t_pixel want_px;
    t_step  directed_steps [DIRECTED_ROWS];

    int  sender_idle_pct = 0;
    int  recv_idle_pct   = 0;
    int  fault_count     = 0;
    int  codes_sent      = 0;
    int  cycle_count     = 0;
    logic receiver_hold  = 1'b0;

    indexed_diff_run_pixel_decoder u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_code_byte  (i_code_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_run_last   (o_run_last),
        .o_frame_last (o_frame_last)
    );

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = idrpd_pkg::CFG_WIDTH;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_code_byte = '0;
        i_out_ready = 1'b0;
    end

    always #4ns i_clk = ~i_clk;

    function void restart_frame();
        last_px = '0;
        foreach (hue_cache[i]) begin
            hue_cache[i] = '0;
        end
        pend_st = PEND_NONE;
        col_cnt = '0;
        row_cnt = '0;
    endfunction

    function void emit_pixels(input logic [23:0] px, input int count);
        int         shade;
        logic [5:0] slot;
        logic       frame_done;
        t_pixel     p;
        for (int k = 0; k < count; k++) begin
            frame_done = 1'b0;
            if (gray_on) begin
                shade = (30 * px[23:16] + 59 * px[15:8] + 11 * px[7:0]) / 100;
                p.red   = shade[7:0];
                p.green = shade[7:0];
                p.blue  = shade[7:0];
            end else begin
                p.red   = px[23:16];
                p.green = px[15:8];
                p.blue  = px[7:0];
            end
            slot = 6'(3 * px[23:16] + 5 * px[15:8] + 7 * px[7:0]);
            hue_cache[slot] = px;
            last_px = px;
            col_cnt = col_cnt + 16'd1;
            if (col_cnt >= width_reg) begin
                col_cnt = '0;
                row_cnt = row_cnt + 16'd1;
                if (row_cnt >= height_reg) begin
                    frame_done = 1'b1;
                end
            end
            p.run_last   = frame_done || (k == count - 1);
            p.frame_last = frame_done;
            fresh_px.push_back(p);
            if (frame_done) begin
                restart_frame();
                break;
            end
        end
    endfunction

    function void decode_byte(input logic [7:0] b);
        logic [7:0] pr;
        logic [7:0] pg;
        logic [7:0] pb;
        logic [7:0] dg;
        pr = last_px[23:16];
        pg = last_px[15:8];
        pb = last_px[7:0];
        dg = {2'b00, luma_first[5:0]};
        case (pend_st)
            PEND_LUMA: begin
                pend_st = PEND_NONE;
                emit_pixels({pr + dg + {4'd0, b[7:4]} - 8'd40, pg + dg - 8'd32,
                             pb + dg + {4'd0, b[3:0]} - 8'd40}, 1);
            end
            PEND_RED: begin
                raw_red = b;
                pend_st = PEND_GREEN;
            end
            PEND_GREEN: begin
                raw_green = b;
                pend_st   = PEND_BLUE;
            end
            PEND_BLUE: begin
                pend_st = PEND_NONE;
                emit_pixels({raw_red, raw_green, b}, 1);
            end
            default: begin
                if (b == idrpd_pkg::TAG_RAW_CODE) begin
                    pend_st = PEND_RED;
                end else if (b == idrpd_pkg::TAG_REPEAT_CODE) begin
                    emit_pixels(last_px, 1);
                end else begin
                    case (b & OP_MASK)
                        OP_INDEX: emit_pixels(hue_cache[b[5:0]], 1);
                        OP_DIFF: emit_pixels({pr + {6'd0, b[5:4]} - 8'd2,
                                              pg + {6'd0, b[3:2]} - 8'd2,
                                              pb + {6'd0, b[1:0]} - 8'd2}, 1);
                        OP_LUMA: begin
                            luma_first = b;
                            pend_st    = PEND_LUMA;
                        end
                        default: emit_pixels(last_px, int'(b) - 191);
                    endcase
                end
            end
        endcase
    endfunction

    function void note_fault(input string what, input t_pixel want, input t_pixel got);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
            $display("%s: expected rgb %h %h %h run_last %b frame_last %b,",
                     what, want.red, want.green, want.blue, want.run_last,
                     want.frame_last);
            $display("    got rgb %h %h %h run_last %b frame_last %b",
                     got.red, got.green, got.blue, got.run_last, got.frame_last);
        end
    endfunction

    function t_step code_row(input logic [7:0] code);
        t_step s;
        s        = '0;
        s.code   = code;
        s.reg_sel = idrpd_pkg::CFG_WIDTH;
        return s;
    endfunction

    // Rows decoded in a one-pixel frame: every pixel closes its frame.
    function t_step typed_row(input logic [7:0] code, input logic [23:0] px);
        t_step s;
        s       = code_row(code);
        s.typed = 1'b1;
        s.want  = {px, 1'b1, 1'b1};
        return s;
    endfunction

    function t_step cfg_row(input idrpd_pkg::t_cfg_reg sel, input logic [15:0] value);
        t_step s;
        s         = '0;
        s.is_cfg  = 1'b1;
        s.reg_sel = sel;
        s.value   = value;
        return s;
    endfunction

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (expected_pixels.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input idrpd_pkg::t_cfg_reg sel, input logic [15:0] value);
        wait_drained();
        i_cfg_valid = 1'b1;
        i_cfg_index = sel;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (sel)
            idrpd_pkg::CFG_WIDTH:  width_reg  = value;
            idrpd_pkg::CFG_HEIGHT: height_reg = value;
            default:               gray_on    = value[0];
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_code(input logic [7:0] code, input logic typed, input t_pixel want);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_code_byte = code;
        do @(posedge i_clk); while (!o_in_ready);
        fresh_px.delete();
        decode_byte(code);
        if (typed) begin
            expected_pixels.push_back(want);
        end else begin
            foreach (fresh_px[i]) begin
                expected_pixels.push_back(fresh_px[i]);
            end
        end
        codes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random_chunk();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            send_code(8'($urandom_range(0, 255)), 1'b0, '0);
        end else if (pick < 24) begin
            send_code(OP_INDEX | 8'($urandom_range(0, 63)), 1'b0, '0);
        end else if (pick < 42) begin
            send_code(OP_DIFF | 8'($urandom_range(0, 63)), 1'b0, '0);
        end else if (pick < 58) begin
            send_code(OP_LUMA | 8'($urandom_range(0, 63)), 1'b0, '0);
            send_code(8'($urandom_range(0, 255)), 1'b0, '0);
        end else if (pick < 72) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 62) : $urandom_range(1, 8);
            send_code(OP_RUN + 8'(len - 1), 1'b0, '0);
        end else if (pick < 90) begin
            send_code(idrpd_pkg::TAG_RAW_CODE, 1'b0, '0);
            repeat (3) send_code(8'($urandom_range(0, 255)), 1'b0, '0);
        end else begin
            send_code(idrpd_pkg::TAG_REPEAT_CODE, 1'b0, '0);
        end
    endtask

    always @(negedge i_clk) begin
        i_out_ready = !receiver_hold && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always begin
        wait (receiver_hold);
        repeat (HOLD_CYCLES) @(negedge i_clk);
        receiver_hold = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_px = {o_red, o_green, o_blue, o_run_last, o_frame_last};
            if (expected_pixels.size() == 0) begin
                note_fault("unexpected pixel", '0, got_px);
            end else begin
                want_px = expected_pixels.pop_front();
                if (got_px !== want_px) begin
                    note_fault("pixel mismatch", want_px, got_px);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("indexed_diff_run_pixel_decoder_test NOT OK");
            $finish;
        end
    end

    initial begin
        int phase_start;
        logic paused;
        logic [15:0] w;
        logic [15:0] h;
        logic g;

        width_reg  = 16'd1;
        height_reg = 16'd1;
        gray_on    = 1'b0;
        restart_frame();

        directed_steps = '{
            typed_row(8'h00, 24'h000000),
            typed_row(8'h55, 24'hFFFFFF),
            typed_row(idrpd_pkg::TAG_REPEAT_CODE, 24'h000000),
            code_row(idrpd_pkg::TAG_RAW_CODE),
            code_row(8'hFF),
            code_row(8'h80),
            typed_row(8'h01, 24'hFF8001),
            typed_row(8'hC0, 24'h000000),
            cfg_row(idrpd_pkg::CFG_WIDTH, 16'd5),
            cfg_row(idrpd_pkg::CFG_HEIGHT, 16'd2),
            code_row(idrpd_pkg::TAG_RAW_CODE),
            code_row(8'h12),
            code_row(8'h34),
            code_row(8'h56),
            code_row(8'h7F),
            code_row(8'h40),
            code_row(8'h80),
            code_row(8'h00),
            code_row(8'hBF),
            code_row(8'hFF),
            code_row(8'h3F),
            code_row(8'hFD),
            code_row(8'hC0),
            cfg_row(idrpd_pkg::CFG_GRAY, 16'd1),
            code_row(idrpd_pkg::TAG_RAW_CODE),
            code_row(8'hFF),
            code_row(8'hFF),
            code_row(8'hFF),
            code_row(8'hFD),
            cfg_row(idrpd_pkg::CFG_GRAY, 16'd0),
            code_row(8'h00)
        };

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_steps[i]) begin
            if (directed_steps[i].is_cfg) begin
                write_register(directed_steps[i].reg_sel, directed_steps[i].value);
            end else begin
                send_code(directed_steps[i].code, directed_steps[i].typed,
                          directed_steps[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph / 2)
                0: begin
                    sender_idle_pct = 31;
                    recv_idle_pct   = 58;
                end
                1: begin
                    sender_idle_pct = 58;
                    recv_idle_pct   = 31;
                end
                default: begin
                    sender_idle_pct = 0;
                    recv_idle_pct   = 0;
                end
            endcase
            case (ph)
                0: begin w = 16'd3;     h = 16'd2;     g = 1'b0; end
                1: begin w = 16'd0;     h = 16'd4;     g = 1'b1; end
                2: begin w = 16'd7;     h = 16'd0;     g = 1'b0; end
                3: begin w = 16'hFFFF;  h = 16'hFFFF;  g = 1'b1; end
                4: begin
                    w = 16'($urandom_range(1, 12));
                    h = 16'($urandom_range(1, 5));
                    g = 1'($urandom_range(0, 1));
                end
                default: begin
                    w = 16'($urandom_range(0, 6));
                    h = 16'($urandom_range(0, 3));
                    g = 1'($urandom_range(0, 1));
                end
            endcase
            write_register(idrpd_pkg::CFG_WIDTH, w);
            write_register(idrpd_pkg::CFG_HEIGHT, h);
            write_register(idrpd_pkg::CFG_GRAY, {15'd0, g});
            if (ph == 0) begin
                receiver_hold = 1'b1;
            end
            phase_start = codes_sent;
            paused      = 1'b0;
            while (codes_sent - phase_start < PHASE_CODES) begin
                send_random_chunk();
                if (ph == 1 && !paused && codes_sent - phase_start >= PHASE_CODES / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        wait_drained();
        if (expected_pixels.size() != 0) begin
            fault_count += expected_pixels.size();
        end
        if (fault_count == 0) begin
            $display("indexed_diff_run_pixel_decoder_test OK");
        end else begin
            $display("indexed_diff_run_pixel_decoder_test NOT OK");
        end
        $finish;
    end
endmodule
